// ----- src/dlb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dlb_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 8;
   localparam int DISC_W   = 8;
   localparam int SEG_W    = 6;

   // Averaging window (1 to 8) and the deficit history it needs
   localparam int AVG_WINDOW = 4;
   localparam int HIST_SLOTS = (AVG_WINDOW > 1) ? AVG_WINDOW - 1 : 1;
   localparam int SUM_W      = SAMPLE_W + $clog2(AVG_WINDOW);

   // Exact floor(sum / AVG_WINDOW) by reciprocal multiply for every sum below 2**SUM_W
   localparam int AVG_SHIFT  = SUM_W + $clog2(AVG_WINDOW);
   localparam int AVG_RECIP  = (2 ** AVG_SHIFT + AVG_WINDOW - 1) / AVG_WINDOW;
   localparam int AVG_PROD_W = SUM_W + AVG_SHIFT + 1;

   // Gain product and noise threshold
   localparam int GAIN_PROD_W = SAMPLE_W + GAIN_W;
   localparam int LEVEL_DIV   = 10;
   localparam int THR_W       = DISC_W + $clog2(LEVEL_DIV);

   // Exact floor(level / LEVEL_DIV) for every 16-bit level
   localparam int SEG_SHIFT  = SAMPLE_W + $clog2(LEVEL_DIV);
   localparam int SEG_RECIP  = (2 ** SEG_SHIFT + LEVEL_DIV - 1) / LEVEL_DIV;
   localparam int SEG_PROD_W = SAMPLE_W + SEG_SHIFT + 1;

   // Bargraph limits and auto-reset hysteresis
   localparam int SEG_MAX   = 40;
   localparam int ARM_ABOVE = 8;
   localparam int REQ_BELOW = 6;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LEVEL     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN           = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISCRIMINATION = 2'd2;

   localparam logic [SAMPLE_W-1:0] ZERO_LEVEL_RESET     = 16'd10;
   localparam logic [GAIN_W-1:0]   GAIN_RESET           = 8'd2;
   localparam logic [DISC_W-1:0]   DISCRIMINATION_RESET = 8'd0;

   typedef struct packed {
      logic [SAMPLE_W-1:0] zero_level;
      logic [GAIN_W-1:0]   gain;
      logic [DISC_W-1:0]   discrimination;
   } dlb_cfg_type;

endpackage

`default_nettype wire

// ----- src/detector_level_to_bargraph.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Detector level to bargraph.
// Input channel req_*: one converter sample per beat, taken at a clock edge with
// req_valid high and req_stall low. Result channel rsp_*: one beat per sample, in
// order, carrying the conditioned level, the bargraph segment count (0 to 40) and
// the one-shot auto-reset request.
// Configuration: csr_write with csr_index selects zero_level (0), gain (1) or
// discrimination (2) and writes csr_wdata; other indexes are dropped. Write only
// while no sample is in flight.
// Throughput: one sample per clock cycle while rsp_stall is low. Five register
// stages (input, deficit sum, window average, gain and threshold, segments) lie
// from req_* to rsp_*; gain and threshold has two multiplies, others one at most.
// Stall: a stalled result holds on rsp_* unchanged; stages behind it keep filling
// until the pipeline is full, then req_stall rises. req_stall is low whenever the
// result register is empty.
// Reset: synchronous, active high; clears the pipeline, the deficit history and
// the auto-reset arm, and loads the register defaults (10, 2, 0).

module detector_level_to_bargraph (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [dlb_pkg::SAMPLE_W-1:0]      req_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [dlb_pkg::SAMPLE_W-1:0]           rsp_level,
   output logic [dlb_pkg::SEG_W-1:0]              rsp_segments,
   output logic                                   rsp_auto_reset_request,
   input  wire logic                              csr_write,
   input  wire logic [dlb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [dlb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dlb_pkg::*;

   dlb_cfg_type         cfg_ff;
   logic                req_ready;
   logic                avg_valid;
   logic                avg_ready;
   logic [SAMPLE_W-1:0] avg_value;
   logic                level_valid;
   logic                level_ready;
   logic [SAMPLE_W-1:0] level_value;

   // Configuration registers; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_level     <= ZERO_LEVEL_RESET;
         cfg_ff.gain           <= GAIN_RESET;
         cfg_ff.discrimination <= DISCRIMINATION_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ZERO_LEVEL:     cfg_ff.zero_level     <= csr_wdata[SAMPLE_W-1:0];
            CSR_GAIN:           cfg_ff.gain           <= csr_wdata[GAIN_W-1:0];
            CSR_DISCRIMINATION: cfg_ff.discrimination <= csr_wdata[DISC_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = !req_ready;

   // Deficit, window sum and average
   dlb_average u_average (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (req_sample),
      .out_valid (avg_valid),
      .out_ready (avg_ready),
      .out_avg   (avg_value)
   );

   // Gain and noise threshold
   dlb_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (avg_valid),
      .in_ready  (avg_ready),
      .in_avg    (avg_value),
      .out_valid (level_valid),
      .out_ready (level_ready),
      .out_level (level_value)
   );

   // Segments, auto-reset hysteresis and the result register
   dlb_bargraph u_bargraph (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (level_valid),
      .in_ready     (level_ready),
      .in_level     (level_value),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_level    (rsp_level),
      .out_segments (rsp_segments),
      .out_request  (rsp_auto_reset_request)
   );

   // Segment count stays within the bargraph
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_segments <= SEG_W'(SEG_MAX))
      else $error("segment count above saturation");

   // Below saturation, segments must be exactly level / 10
   a_seg_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_segments < SEG_W'(SEG_MAX) |->
         (32'(rsp_level) >= 32'(rsp_segments) * 32'(LEVEL_DIV)) &&
         (32'(rsp_level) < 32'(rsp_segments) * 32'(LEVEL_DIV) + 32'(LEVEL_DIV)))
      else $error("segment count does not match level");

   // A request only fires on a low segment count
   a_req_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_auto_reset_request |-> rsp_segments < SEG_W'(REQ_BELOW))
      else $error("auto-reset request with high segment count");

   // An empty result register never backs up the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ----- src/dlb_average.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dlb_average (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire dlb_pkg::dlb_cfg_type           cfg,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [dlb_pkg::SAMPLE_W-1:0]   in_sample,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic [dlb_pkg::SAMPLE_W-1:0]        out_avg
);
   import dlb_pkg::*;

   logic                  sample_valid_ff;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic                  sum_valid_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [SUM_W-1:0]      sum_in;
   logic                  avg_valid_ff;
   logic [SAMPLE_W-1:0]   avg_ff;
   logic [SAMPLE_W-1:0]   deficit;
   logic [AVG_PROD_W-1:0] avg_prod;
   logic                  sum_ready;
   logic                  avg_ready;
   logic                  shift_en;

   assign avg_ready = !avg_valid_ff || out_ready;
   assign sum_ready = !sum_valid_ff || avg_ready;
   assign in_ready  = !sample_valid_ff || sum_ready;
   assign shift_en  = sample_valid_ff && sum_ready;

   // Deficit below the zero level; a sample above it counts as no signal
   assign deficit = (sample_ff > cfg.zero_level) ? '0 : cfg.zero_level - sample_ff;

   if (AVG_WINDOW > 1) begin : g_hist
      logic [SAMPLE_W-1:0] hist_ff [HIST_SLOTS];

      always_comb begin
         sum_in = SUM_W'(deficit);
         for (int i = 0; i < HIST_SLOTS; i++) begin
            sum_in = sum_in + SUM_W'(hist_ff[i]);
         end
      end

      // Shift the newest deficit in as its item moves on
      always_ff @(posedge clock) begin
         if (reset) begin
            for (int i = 0; i < HIST_SLOTS; i++) begin
               hist_ff[i] <= '0;
            end
         end else if (shift_en) begin
            for (int i = 0; i < HIST_SLOTS - 1; i++) begin
               hist_ff[i] <= hist_ff[i + 1];
            end
            hist_ff[HIST_SLOTS - 1] <= deficit;
         end
      end
   end else begin : g_nohist
      assign sum_in = SUM_W'(deficit);
   end

   assign avg_prod = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
         sum_valid_ff    <= 1'b0;
         avg_valid_ff    <= 1'b0;
      end else begin
         if (in_ready)  sample_valid_ff <= in_valid;
         if (sum_ready) sum_valid_ff    <= sample_valid_ff;
         if (avg_ready) avg_valid_ff    <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) sample_ff <= in_sample;
      if (shift_en)             sum_ff    <= sum_in;
      if (avg_ready && sum_valid_ff) avg_ff <= avg_prod[AVG_SHIFT +: SAMPLE_W];
   end

   assign out_valid = avg_valid_ff;
   assign out_avg   = avg_ff;

endmodule

`default_nettype wire

// ----- src/dlb_gain.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dlb_gain (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire dlb_pkg::dlb_cfg_type           cfg,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [dlb_pkg::SAMPLE_W-1:0]   in_avg,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic [dlb_pkg::SAMPLE_W-1:0]        out_level
);
   import dlb_pkg::*;

   logic                   level_valid_ff;
   logic [SAMPLE_W-1:0]    level_ff;
   logic [SAMPLE_W-1:0]    level_in;
   logic [GAIN_PROD_W-1:0] gain_prod;
   logic [SAMPLE_W-1:0]    raw_level;
   logic [THR_W-1:0]       threshold;

   assign in_ready = !level_valid_ff || out_ready;

   // Keep the low 16 bits of avg * gain, then halve
   assign gain_prod = GAIN_PROD_W'(in_avg) * GAIN_PROD_W'(cfg.gain);
   assign raw_level = {1'b0, gain_prod[SAMPLE_W-1:1]};
   assign threshold = THR_W'(cfg.discrimination) * THR_W'(LEVEL_DIV);
   assign level_in  = (raw_level > SAMPLE_W'(threshold)) ? raw_level : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_valid_ff <= 1'b0;
      end else if (in_ready) begin
         level_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) level_ff <= level_in;
   end

   assign out_valid = level_valid_ff;
   assign out_level = level_ff;

endmodule

`default_nettype wire

// ----- src/dlb_bargraph.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dlb_bargraph (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [dlb_pkg::SAMPLE_W-1:0]   in_level,
   output logic                                out_valid,
   input  wire logic                           out_stall,
   output logic [dlb_pkg::SAMPLE_W-1:0]        out_level,
   output logic [dlb_pkg::SEG_W-1:0]           out_segments,
   output logic                                out_request
);
   import dlb_pkg::*;

   logic                  valid_ff;
   logic [SAMPLE_W-1:0]   level_ff;
   logic [SEG_W-1:0]      segments_ff;
   logic [SEG_W-1:0]      segments_in;
   logic                  request_ff;
   logic                  request_in;
   logic                  armed_ff;
   logic                  armed_in;
   logic [SEG_PROD_W-1:0] seg_prod;
   logic [SAMPLE_W-1:0]   seg_full;
   logic                  load;

   assign in_ready = !valid_ff || !out_stall;
   assign load     = in_ready && in_valid;

   assign seg_prod    = SEG_PROD_W'(in_level) * SEG_PROD_W'(SEG_RECIP);
   assign seg_full    = seg_prod[SEG_SHIFT +: SAMPLE_W];
   assign segments_in = (seg_full > SAMPLE_W'(SEG_MAX)) ? SEG_W'(SEG_MAX)
                                                        : seg_full[SEG_W-1:0];

   // Arm on a strong signal; fire once and disarm when it drops low
   always_comb begin
      armed_in   = armed_ff;
      request_in = 1'b0;
      if (segments_in > SEG_W'(ARM_ABOVE)) armed_in = 1'b1;
      if (segments_in < SEG_W'(REQ_BELOW) && armed_in) begin
         request_in = 1'b1;
         armed_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         armed_ff <= 1'b0;
      end else begin
         if (in_ready) valid_ff <= in_valid;
         if (load)     armed_ff <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         level_ff    <= in_level;
         segments_ff <= segments_in;
         request_ff  <= request_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_level    = level_ff;
   assign out_segments = segments_ff;
   assign out_request  = request_ff;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import dlb_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 5;
   // input, deficit sum, average, gain/threshold, segments
   localparam int PIPE_DEPTH    = 5;
   localparam int STALL_LIMIT   = 4000;
   localparam int IDLE_PERCENT  = 11;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 110;
   localparam int QUIET_PHASE   = 3;
   // index past the register list; the block must drop writes to it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] level;
      logic [SEG_W-1:0]    segments;
      logic                auto_reset;
   } bargraph_beat_type;

   // Tracks register contents, deficit history and the auto-reset arm, and
   // holds the bargraph beats still owed by the block.
   class bargraph_book;
      logic [SAMPLE_W-1:0] zero_level;
      logic [GAIN_W-1:0]   gain;
      logic [DISC_W-1:0]   discrimination;
      logic [SAMPLE_W-1:0] deficits [HIST_SLOTS];
      bit                  armed;
      bargraph_beat_type   pending_beats [$];
      int                  mismatches;

      function new();
         zero_level     = ZERO_LEVEL_RESET;
         gain           = GAIN_RESET;
         discrimination = DISCRIMINATION_RESET;
         foreach (deficits[i]) deficits[i] = '0;
         armed      = 1'b0;
         mismatches = 0;
      endfunction

      function void apply_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ZERO_LEVEL:     zero_level     = data[SAMPLE_W-1:0];
            CSR_GAIN:           gain           = data[GAIN_W-1:0];
            CSR_DISCRIMINATION: discrimination = data[DISC_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] sample);
         logic [SAMPLE_W-1:0]    deficit;
         logic [SUM_W-1:0]       sum;
         logic [SAMPLE_W-1:0]    avg;
         logic [GAIN_PROD_W-1:0] prod;
         logic [SAMPLE_W-1:0]    level;
         logic [THR_W-1:0]       threshold;
         int                     seg;
         bargraph_beat_type      beat;

         deficit = (sample > zero_level) ? '0 : zero_level - sample;
         // full-width sum over the window, then shift the new deficit in
         sum = SUM_W'(deficit);
         for (int i = 0; i + 1 < AVG_WINDOW; i++) sum += SUM_W'(deficits[i]);
         for (int i = 0; i + 2 < AVG_WINDOW; i++) deficits[i] = deficits[i + 1];
         if (AVG_WINDOW >= 2) deficits[HIST_SLOTS - 1] = deficit;
         avg = SAMPLE_W'(sum / AVG_WINDOW);

         prod  = avg * gain;
         level = {1'b0, prod[SAMPLE_W-1:1]};
         threshold = THR_W'(discrimination) * THR_W'(LEVEL_DIV);
         if (!(level > threshold)) level = '0;

         seg = level / LEVEL_DIV;
         if (seg > SEG_MAX) seg = SEG_MAX;
         if (seg > ARM_ABOVE) armed = 1'b1;
         beat.auto_reset = 1'b0;
         if (seg < REQ_BELOW && armed) begin
            beat.auto_reset = 1'b1;
            armed = 1'b0;
         end
         beat.level    = level;
         beat.segments = seg[SEG_W-1:0];
         pending_beats.push_back(beat);
      endfunction

      function void check_result(bargraph_beat_type got);
         bargraph_beat_type want;
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected beat level=%0d segments=%0d request=%0b",
                        $realtime, got.level, got.segments, got.auto_reset);
            return;
         end
         want = pending_beats.pop_front();
         if (got.level !== want.level || got.segments !== want.segments ||
             got.auto_reset !== want.auto_reset) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: level %0d/%0d segments %0d/%0d request %0b/%0b (exp/act)",
                        $realtime, want.level, got.level, want.segments, got.segments,
                        want.auto_reset, got.auto_reset);
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_valid  = 1'b0;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   rsp_stall  = 1'b0;
   logic                   csr_write  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   logic [SAMPLE_W-1:0]    rsp_level;
   logic [SEG_W-1:0]       rsp_segments;
   logic                   rsp_auto_reset_request;

   bargraph_book bargraph;
   bit quiet      = 1'b0;
   bit strong_run = 1'b0;
   int run_left   = 0;
   int idle_cycles = 0;

   // Directed beats: window edges at the default setting, then arm and request
   logic [SAMPLE_W-1:0] default_samples [4]  = '{16'd0, 16'd10, 16'd11, 16'hFFFF};
   logic [SAMPLE_W-1:0] arm_samples     [13] = '{16'd0, 16'd0, 16'd0, 16'd0,
                                                 16'd1000, 16'd1000, 16'd1000, 16'd1000,
                                                 16'd930, 16'd930, 16'd930, 16'd930,
                                                 16'd1001};
   logic [SAMPLE_W-1:0] extreme_samples [4]  = '{16'd0, 16'hFFFF, 16'h5555, 16'hAAAA};

   detector_level_to_bargraph DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_sample             (req_sample),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_level              (rsp_level),
      .rsp_segments           (rsp_segments),
      .rsp_auto_reset_request (rsp_auto_reset_request),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial forever #CLOCK_HALF clock = ~clock;

   // Check the result beat before noting the input beat of the same edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         bargraph.check_result('{rsp_level, rsp_segments, rsp_auto_reset_request});
      if (!reset && req_valid && !req_stall)
         bargraph.note_sample(req_sample);
   end

   // Stall the result side at random, except through the quiet phase
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Give up when no beat moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one sample beat, with random idle cycles in front, and hold it
   // until the block takes it.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Drop valid, wait for every owed beat, then let the pipeline empty out.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (bargraph.pending_beats.size() != 0);
      repeat (PIPE_DEPTH + 1) @(posedge clock);
   endtask

   // Write all three registers back to back, optionally followed by a write
   // to the unused index with random data.
   task automatic program_registers(input logic [CSR_DATA_W-1:0] zl_data,
                                    input logic [CSR_DATA_W-1:0] gain_data,
                                    input logic [CSR_DATA_W-1:0] disc_data,
                                    input bit with_spare);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  val [4];
      int count;
      idx = '{CSR_ZERO_LEVEL, CSR_GAIN, CSR_DISCRIMINATION, CSR_SPARE};
      val = '{zl_data, gain_data, disc_data, 16'($urandom())};
      count = with_spare ? 4 : 3;
      for (int k = 0; k < count; k++) begin
         csr_write <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         bargraph.apply_write(idx[k], val[k]);
      end
      csr_write <= 1'b0;
   endtask

   // Alternate runs of strong signal (deep below zero level) and weak signal
   // (at, just under or above it) so the arm/request hysteresis gets exercised; mix
   // in plain noise.
   function automatic logic [SAMPLE_W-1:0] next_sample();
      logic [SAMPLE_W-1:0] zl;
      int span;
      zl = bargraph.zero_level;
      if (run_left == 0) begin
         strong_run = !strong_run;
         run_left   = $urandom_range(12, 2);
      end
      run_left--;
      if ($urandom_range(99) < 20) return 16'($urandom());
      if (strong_run) return 16'($urandom_range(zl / 2));
      if ($urandom_range(1)) begin
         span = (zl < 60) ? zl : 60;
         return zl - 16'($urandom_range(span));
      end
      return 16'($urandom_range(16'hFFFF, zl));
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] zl_data, gain_data, disc_data;
      bargraph = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Defaults: sample at, below and above the zero level, plus extremes
      foreach (default_samples[i]) send_sample(default_samples[i]);

      // Arm on a strong signal, request on the drop to 0 segments, then rise to 7 and
      // fall to 5 with no second request; gain written with junk in the upper byte
      wait_for_idle();
      program_registers(16'd1000, 16'hFF02, 16'h0000, 1'b1);
      foreach (arm_samples[i]) send_sample(arm_samples[i]);

      // Largest zero level, gain and threshold
      wait_for_idle();
      program_registers(16'hFFFF, 16'h00FF, 16'h00FF, 1'b0);
      foreach (extreme_samples[i]) send_sample(extreme_samples[i]);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_idle();
         case (p)
            0: begin
               zl_data = 16'h0000; gain_data = 16'h0000; disc_data = 16'h0000;
            end
            RANDOM_PHASES - 1: begin
               zl_data = 16'hFFFF; gain_data = 16'hFFFF; disc_data = 16'h0000;
            end
            default: begin
               case ($urandom_range(3))
                  0: zl_data = 16'($urandom());
                  1: zl_data = 16'($urandom_range(2000, 50));
                  2: zl_data = 16'hFFFF;
                  default: zl_data = 16'($urandom_range(400, 1));
               endcase
               gain_data = 16'($urandom());
               if ($urandom_range(3) == 0)
                  disc_data = 16'($urandom());
               else
                  disc_data = {8'($urandom()), 8'($urandom_range(30))};
            end
         endcase
         program_registers(zl_data, gain_data, disc_data, $urandom_range(1));
         // one phase runs without idling on either side
         quiet = (p == QUIET_PHASE);
         repeat (PHASE_ITEMS) send_sample(next_sample());
      end

      quiet = 1'b0;
      wait_for_idle();
      if (bargraph.mismatches == 0 && bargraph.pending_beats.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
src/dlb_pkg.sv
src/dlb_average.sv
src/dlb_gain.sv
src/dlb_bargraph.sv
src/detector_level_to_bargraph.sv
sim/testbench.sv
